// ===== design/tcc_pkg.sv =====
package tcc_pkg;

    // field and fixed point sizes
    localparam int CODE_BITS = 12;
    localparam int FRAC_BITS = 16;
    localparam int NUM_REGS  = 8;
    localparam int ADDR_W    = 5;
    localparam int OUT_W     = 17;
    localparam int OUT_MAX   = 65535;
    localparam int OUT_MIN_M = 65536;

    // derived datapath widths
    localparam int REF_W   = 11;
    localparam int V_W     = CODE_BITS + REF_W;
    localparam int DV_W    = V_W + 1;
    localparam int T_W     = FRAC_BITS + 9;
    localparam int DT_W    = T_W + 1;
    localparam int DR_W    = 9;
    localparam int N1_W    = V_W + 1;
    localparam int F1_W    = V_W + FRAC_BITS + 2;
    localparam int LO1_W   = F1_W / 2;
    localparam int PL1_W   = DR_W + LO1_W + 1;
    localparam int PH1_W   = DR_W + F1_W - LO1_W;
    localparam int RM_W    = F1_W + DR_W + 1;
    localparam int LO2_W   = RM_W / 2;
    localparam int PL2_W   = CODE_BITS + 1 + LO2_W + 1;
    localparam int PH2_W   = CODE_BITS + 1 + RM_W - LO2_W;
    localparam int N2_W    = RM_W + CODE_BITS + 1;
    localparam int DIV_W   = N2_W;
    localparam int F2_LIM  = 2 * FRAC_BITS + 10;
    localparam int F2_W    = F2_LIM + 2;
    localparam int LO3_W   = F2_W / 2;
    localparam int PL3_W   = DT_W + LO3_W + 1;
    localparam int PH3_W   = DT_W + F2_W - LO3_W;
    localparam int P_W     = DT_W + F2_W;
    localparam int R_W     = P_W - FRAC_BITS;
    localparam int TQ_W    = R_W + 2;
    localparam int M8_W    = TQ_W - (FRAC_BITS - 8);

    // result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_SAT   = 2'd1,
        ST_DEGEN = 2'd2
    } t_status;

    // register map
    typedef enum logic [2:0] {
        REG_ROOM_WHOLE = 3'd0,
        REG_ROOM_DIGIT = 3'd1,
        REG_HOT_WHOLE  = 3'd2,
        REG_HOT_DIGIT  = 3'd3,
        REG_ROOM_CODE  = 3'd4,
        REG_HOT_CODE   = 3'd5,
        REG_ROOM_TRIM  = 3'd6,
        REG_HOT_TRIM   = 3'd7
    } t_reg_idx;

    // side data that rides through a divider
    typedef struct packed {
        logic                 neg;
        logic [CODE_BITS-1:0] code;
    } t_div_side;

    localparam longint FRAC_ONE = longint'(1) << FRAC_BITS;

    // fraction of a degree for a decimal tenths digit (10 to 15 give hundredths), rounded to nearest
    function automatic logic [FRAC_BITS-1:0] frac_of(input logic [3:0] digit);
        case (digit)
            4'd0:    frac_of = '0;
            4'd1:    frac_of = FRAC_BITS'((1 * FRAC_ONE + 5) / 10);
            4'd2:    frac_of = FRAC_BITS'((2 * FRAC_ONE + 5) / 10);
            4'd3:    frac_of = FRAC_BITS'((3 * FRAC_ONE + 5) / 10);
            4'd4:    frac_of = FRAC_BITS'((4 * FRAC_ONE + 5) / 10);
            4'd5:    frac_of = FRAC_BITS'((5 * FRAC_ONE + 5) / 10);
            4'd6:    frac_of = FRAC_BITS'((6 * FRAC_ONE + 5) / 10);
            4'd7:    frac_of = FRAC_BITS'((7 * FRAC_ONE + 5) / 10);
            4'd8:    frac_of = FRAC_BITS'((8 * FRAC_ONE + 5) / 10);
            4'd9:    frac_of = FRAC_BITS'((9 * FRAC_ONE + 5) / 10);
            4'd10:   frac_of = FRAC_BITS'((10 * FRAC_ONE + 50) / 100);
            4'd11:   frac_of = FRAC_BITS'((11 * FRAC_ONE + 50) / 100);
            4'd12:   frac_of = FRAC_BITS'((12 * FRAC_ONE + 50) / 100);
            4'd13:   frac_of = FRAC_BITS'((13 * FRAC_ONE + 50) / 100);
            4'd14:   frac_of = FRAC_BITS'((14 * FRAC_ONE + 50) / 100);
            4'd15:   frac_of = FRAC_BITS'((15 * FRAC_ONE + 50) / 100);
            default: frac_of = '0;
        endcase
    endfunction

endpackage

// ===== design/tcc_if.sv =====
interface tcc_in_if import tcc_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CODE_BITS-1:0] sensor_code;

    modport source (output valid, output sensor_code, input ready);
    modport sink (input valid, input sensor_code, output ready);
endinterface

interface tcc_out_if import tcc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] temp_q8;
    logic [1:0]              status;

    modport source (output valid, output temp_q8, output status, input ready);
    modport sink (input valid, input temp_q8, input status, output ready);
endinterface

// ===== design/tcc_div.sv =====
module tcc_div import tcc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_vld,
    input  t_div_side        i_side,
    input  logic [DIV_W-1:0] i_num,
    input  logic [V_W-1:0]   i_den,
    output logic             o_vld,
    output t_div_side        o_side,
    output logic [DIV_W-1:0] o_quo
);

    logic             r_vld  [DIV_W];
    t_div_side        r_side [DIV_W];
    logic [V_W-1:0]   r_rem  [DIV_W];
    logic [DIV_W-1:0] r_nq   [DIV_W];

    // one quotient bit per stage, numerator bits shift out as quotient bits shift in
    for (genvar k = 0; k < DIV_W; k++) begin : g_step
        logic             n_vld_in;
        t_div_side        n_side_in;
        logic [V_W-1:0]   n_rem_in;
        logic [DIV_W-1:0] n_nq_in;
        logic [V_W:0]     n_trial;
        logic             n_ge;

        if (k == 0) begin : g_first
            assign n_vld_in  = i_vld;
            assign n_side_in = i_side;
            assign n_rem_in  = '0;
            assign n_nq_in   = i_num;
        end else begin : g_next
            assign n_vld_in  = r_vld[k-1];
            assign n_side_in = r_side[k-1];
            assign n_rem_in  = r_rem[k-1];
            assign n_nq_in   = r_nq[k-1];
        end

        // trial subtract
        assign n_trial = {n_rem_in, n_nq_in[DIV_W-1]};
        assign n_ge    = (n_trial >= {1'b0, i_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= n_vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= n_side_in;
                r_rem[k]  <= n_ge ? V_W'(n_trial - {1'b0, i_den}) : V_W'(n_trial);
                r_nq[k]   <= {n_nq_in[DIV_W-2:0], n_ge};
            end
        end
    end

    assign o_vld  = r_vld[DIV_W-1];
    assign o_side = r_side[DIV_W-1];
    assign o_quo  = r_nq[DIV_W-1];

endmodule

// ===== design/temp_sensor_two_point_conversion.sv =====
// throughput: one reading per cycle while the output buffer is not full and no register write
// holds input off, set by the two pipelined dividers (one quotient bit a stage)
// a two-entry output buffer lets the pipeline keep accepting while one result waits
// input is held off after a register write while calibration terms settle
// synchronous active-low reset clears the configuration registers to 0, empties the pipeline and buffer
module temp_sensor_two_point_conversion import tcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    tcc_in_if.sink            i_smp,
    tcc_out_if.source         o_res
);

    typedef struct packed {
        logic signed [OUT_W-1:0] temp;
        t_status                 status;
    } t_res;

    localparam logic [9:0] MILLI = 10'd1000;

    // configuration registers
    logic [7:0]           r_room_whole, r_hot_whole;
    logic [3:0]           r_room_digit, r_hot_digit;
    logic [CODE_BITS-1:0] r_room_code, r_hot_code;
    logic [7:0]           r_room_trim, r_hot_trim;
    logic [2:0]           r_hold;
    logic                 w_cfg_wr;
    t_reg_idx             w_idx;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_room_whole <= '0;
            r_room_digit <= '0;
            r_hot_whole  <= '0;
            r_hot_digit  <= '0;
            r_room_code  <= '0;
            r_hot_code   <= '0;
            r_room_trim  <= '0;
            r_hot_trim   <= '0;
            r_hold       <= '0;
        end else begin
            if (w_cfg_wr) begin
                r_hold <= 3'd4;
                case (w_idx)
                    REG_ROOM_WHOLE: r_room_whole <= pwdata[7:0];
                    REG_ROOM_DIGIT: r_room_digit <= pwdata[3:0];
                    REG_HOT_WHOLE:  r_hot_whole  <= pwdata[7:0];
                    REG_HOT_DIGIT:  r_hot_digit  <= pwdata[3:0];
                    REG_ROOM_CODE:  r_room_code  <= pwdata[CODE_BITS-1:0];
                    REG_HOT_CODE:   r_hot_code   <= pwdata[CODE_BITS-1:0];
                    REG_ROOM_TRIM:  r_room_trim  <= pwdata[7:0];
                    REG_HOT_TRIM:   r_hot_trim   <= pwdata[7:0];
                    default: ;
                endcase
            end else if (r_hold != 3'd0) begin
                r_hold <= r_hold - 3'd1;
            end
        end
    end

    // register readback
    always_comb begin
        case (w_idx)
            REG_ROOM_WHOLE: prdata = 32'(r_room_whole);
            REG_ROOM_DIGIT: prdata = 32'(r_room_digit);
            REG_HOT_WHOLE:  prdata = 32'(r_hot_whole);
            REG_HOT_DIGIT:  prdata = 32'(r_hot_digit);
            REG_ROOM_CODE:  prdata = 32'(r_room_code);
            REG_HOT_CODE:   prdata = 32'(r_hot_code);
            REG_ROOM_TRIM:  prdata = 32'(r_room_trim);
            REG_HOT_TRIM:   prdata = 32'(r_hot_trim);
            default:        prdata = '0;
        endcase
    end

    // calibration terms, recomputed every cycle from the registers
    logic [T_W-1:0]         r_t_room, r_t_hot;
    logic [REF_W-1:0]       r_rr, r_rh;
    logic [V_W-1:0]         r_vr, r_vh;
    logic signed [DT_W-1:0] r_dt;
    logic signed [DR_W-1:0] r_dr;
    logic signed [DV_W-1:0] r_dv;
    logic                   r_dv_neg, r_degen;
    logic [V_W-1:0]         r_dv_abs, r_half;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_room <= '0;
            r_t_hot  <= '0;
            r_rr     <= REF_W'(MILLI);
            r_rh     <= REF_W'(MILLI);
            r_vr     <= '0;
            r_vh     <= '0;
            r_dt     <= '0;
            r_dr     <= '0;
            r_dv     <= '0;
            r_dv_neg <= 1'b0;
            r_dv_abs <= '0;
            r_half   <= '0;
            r_degen  <= 1'b1;
        end else begin
            r_t_room <= T_W'({r_room_whole, frac_of(r_room_digit)});
            r_t_hot  <= T_W'({r_hot_whole, frac_of(r_hot_digit)});
            r_rr     <= REF_W'(MILLI) - {{(REF_W-8){r_room_trim[7]}}, r_room_trim};
            r_rh     <= REF_W'(MILLI) - {{(REF_W-8){r_hot_trim[7]}}, r_hot_trim};
            r_vr     <= V_W'(r_room_code * r_rr);
            r_vh     <= V_W'(r_hot_code * r_rh);
            r_dt     <= $signed({1'b0, r_t_hot}) - $signed({1'b0, r_t_room});
            r_dr     <= DR_W'($signed({1'b0, r_rh}) - $signed({1'b0, r_rr}));
            r_dv     <= $signed({1'b0, r_vh}) - $signed({1'b0, r_vr});
            r_dv_neg <= r_dv[DV_W-1];
            r_dv_abs <= r_dv[DV_W-1] ? V_W'(-r_dv) : V_W'(r_dv);
            r_half   <= r_dv[DV_W-1] ? V_W'((-r_dv) >>> 1) : V_W'(r_dv >>> 1);
            r_degen  <= (r_dt == '0) || (r_dv == '0);
        end
    end

    // output buffer and pipeline enable
    t_res       r_fd [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       w_en, w_push, w_pop;

    assign w_en        = (r_cnt != 2'd2);
    assign i_smp.ready = w_en && (r_hold == 3'd0);

    // pipeline registers
    logic                    r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7, r_v8;
    logic                    r_v9, r_v10, r_v11, r_v12, r_v13, r_v14, r_v15;
    logic [CODE_BITS-1:0]    r_code0, r_code1, r_code2, r_code3, r_code4, r_code5;
    logic signed [N1_W-1:0]  r_n1;
    logic [DIV_W-1:0]        r_a1, r_a2;
    logic                    r_neg1, r_neg2;
    logic signed [F1_W-1:0]  r_f1;
    logic signed [PL1_W-1:0] r_pl1;
    logic signed [PH1_W-1:0] r_ph1;
    logic signed [RM_W-1:0]  r_rm;
    logic signed [PL2_W-1:0] r_pl2;
    logic signed [PH2_W-1:0] r_ph2;
    logic signed [N2_W-1:0]  r_n2;
    logic signed [F2_W-1:0]  r_f2;
    logic signed [PL3_W-1:0] r_pl3;
    logic signed [PH3_W-1:0] r_ph3;
    logic signed [P_W-1:0]   r_p;
    logic [P_W-1:0]          r_mp;
    logic                    r_neg3, r_neg4;
    logic signed [TQ_W-1:0]  r_tq;
    logic [TQ_W-1:0]         r_mt;
    t_res                    r_t8;

    logic                    w_d1_vld, w_d2_vld;
    t_div_side               w_d1_side, w_d2_side;
    logic [DIV_W-1:0]        w_d1_quo, w_d2_quo;
    t_div_side               n_d1_side, n_d2_side;

    // combinational terms of the pipeline stages
    logic [V_W-1:0]          n_abs_n1;
    logic [DIV_W-1:0]        n_abs_n2;
    logic [F2_LIM:0]         n_q2c;
    logic [R_W-1:0]          n_r;
    logic signed [TQ_W-1:0]  n_rs;
    logic [M8_W-1:0]         n_m8;
    logic                    n_sat;
    t_res                    n_t8;

    assign n_abs_n1 = r_n1[N1_W-1] ? V_W'(-r_n1) : V_W'(r_n1);
    assign n_abs_n2 = r_n2[N2_W-1] ? DIV_W'(-r_n2) : DIV_W'(r_n2);
    assign n_q2c    = (|w_d2_quo[DIV_W-1:F2_LIM]) ? {1'b1, {F2_LIM{1'b0}}}
                                                  : {1'b0, w_d2_quo[F2_LIM-1:0]};
    assign n_r      = r_mp[P_W-1:FRAC_BITS];
    assign n_rs     = r_neg3 ? -$signed(TQ_W'(n_r)) : $signed(TQ_W'(n_r));
    assign n_m8     = r_mt[TQ_W-1:FRAC_BITS-8];

    assign n_d1_side.neg  = r_neg1;
    assign n_d1_side.code = r_code2;
    assign n_d2_side.neg  = r_neg2;
    assign n_d2_side.code = r_code5;

    // final rounding, clamping and status
    always_comb begin
        if (r_neg4) begin
            n_sat = (n_m8 > M8_W'(OUT_MIN_M));
        end else begin
            n_sat = (n_m8 > M8_W'(OUT_MAX));
        end
        if (r_degen) begin
            n_t8.temp   = '0;
            n_t8.status = ST_DEGEN;
        end else if (n_sat) begin
            n_t8.temp   = r_neg4 ? -$signed(OUT_W'(OUT_MIN_M)) : $signed(OUT_W'(OUT_MAX));
            n_t8.status = ST_SAT;
        end else begin
            n_t8.temp   = r_neg4 ? -$signed(OUT_W'(n_m8)) : $signed(OUT_W'(n_m8));
            n_t8.status = ST_OK;
        end
    end

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            {r_v0, r_v1, r_v2, r_v3, r_v4, r_v5, r_v6, r_v7} <= '0;
            {r_v8, r_v9, r_v10, r_v11, r_v12, r_v13, r_v14, r_v15} <= '0;
        end else if (w_en) begin
            r_v0  <= i_smp.valid && i_smp.ready;
            r_v1  <= r_v0;
            r_v2  <= r_v1;
            r_v3  <= w_d1_vld;
            r_v4  <= r_v3;
            r_v5  <= r_v4;
            r_v6  <= r_v5;
            r_v7  <= r_v6;
            r_v8  <= r_v7;
            r_v9  <= w_d2_vld;
            r_v10 <= r_v9;
            r_v11 <= r_v10;
            r_v12 <= r_v11;
            r_v13 <= r_v12;
            r_v14 <= r_v13;
            r_v15 <= r_v14;
        end
    end

    // datapath stages
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            // coarse numerator
            r_code0 <= i_smp.sensor_code;
            r_code1 <= r_code0;
            r_n1    <= $signed(N1_W'(r_code0 * MILLI)) - $signed(N1_W'(r_vr));
            r_code2 <= r_code1;
            r_a1    <= DIV_W'({n_abs_n1, {FRAC_BITS{1'b0}}}) + DIV_W'(r_half);
            r_neg1  <= r_n1[N1_W-1] ^ r_dv_neg;
            // reference at the coarse temperature
            r_code3 <= w_d1_side.code;
            r_f1    <= w_d1_side.neg ? -$signed(F1_W'(w_d1_quo)) : $signed(F1_W'(w_d1_quo));
            r_code4 <= r_code3;
            r_pl1   <= r_dr * $signed({1'b0, r_f1[LO1_W-1:0]});
            r_ph1   <= r_dr * $signed(r_f1[F1_W-1:LO1_W]);
            r_code5 <= r_code4;
            r_rm    <= (RM_W'(r_ph1) <<< LO1_W) + RM_W'(r_pl1)
                     + $signed(RM_W'({r_rr, {FRAC_BITS{1'b0}}}));
            // fine numerator
            r_pl2   <= $signed({1'b0, r_code5}) * $signed({1'b0, r_rm[LO2_W-1:0]});
            r_ph2   <= $signed({1'b0, r_code5}) * $signed(r_rm[RM_W-1:LO2_W]);
            r_n2    <= (N2_W'(r_ph2) <<< LO2_W) + N2_W'(r_pl2)
                     - $signed(N2_W'({r_vr, {FRAC_BITS{1'b0}}}));
            r_a2    <= n_abs_n2 + DIV_W'(r_half);
            r_neg2  <= r_n2[N2_W-1] ^ r_dv_neg;
            // second interpolation
            r_f2    <= w_d2_side.neg ? -$signed(F2_W'(n_q2c)) : $signed(F2_W'(n_q2c));
            r_pl3   <= r_dt * $signed({1'b0, r_f2[LO3_W-1:0]});
            r_ph3   <= r_dt * $signed(r_f2[F2_W-1:LO3_W]);
            r_p     <= (P_W'(r_ph3) <<< LO3_W) + P_W'(r_pl3);
            r_mp    <= (r_p[P_W-1] ? P_W'(-r_p) : P_W'(r_p)) + (P_W'(1) << (FRAC_BITS - 1));
            r_neg3  <= r_p[P_W-1];
            r_tq    <= n_rs + $signed(TQ_W'(r_t_room));
            r_mt    <= (r_tq[TQ_W-1] ? TQ_W'(-r_tq) : TQ_W'(r_tq))
                     + (TQ_W'(1) << (FRAC_BITS - 9));
            r_neg4  <= r_tq[TQ_W-1];
            r_t8    <= n_t8;
        end
    end

    tcc_div u_div1 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v2),
        .i_side  (n_d1_side),
        .i_num   (r_a1),
        .i_den   (r_dv_abs),
        .o_vld   (w_d1_vld),
        .o_side  (w_d1_side),
        .o_quo   (w_d1_quo)
    );

    tcc_div u_div2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_vld   (r_v8),
        .i_side  (n_d2_side),
        .i_num   (r_a2),
        .i_den   (r_dv_abs),
        .o_vld   (w_d2_vld),
        .o_side  (w_d2_side),
        .o_quo   (w_d2_quo)
    );

    // output buffer
    assign w_push = w_en && r_v15;
    assign w_pop  = o_res.valid && o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fd[r_wp] <= r_t8;
        end
    end

    assign o_res.valid   = (r_cnt != 2'd0);
    assign o_res.temp_q8 = r_fd[r_rp].temp;
    assign o_res.status  = r_fd[r_rp].status;

    // checks
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && r_degen |-> o_res.status == ST_DEGEN && o_res.temp_q8 == '0)
        else $error("degenerate calibration gave a nonzero result");

    a_sat_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid && o_res.status == ST_SAT |->
            o_res.temp_q8 == $signed(OUT_W'(OUT_MAX)) ||
            o_res.temp_q8 == -$signed(OUT_W'(OUT_MIN_M)))
        else $error("saturated result not at a limit");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_v15) && $stable(r_t8) && $stable(r_v9))
        else $error("pipeline moved while stalled");

    a_cfg_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> !i_smp.ready)
        else $error("input taken right after a register write");

endmodule

// ===== test/temp_conv_checker.sv =====
`timescale 1ns / 100ps

module temp_conv_checker import tcc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    tcc_in_if                 smp,
    tcc_out_if                res,
    output int                o_fail_count,
    output int                o_pending,
    output int                o_conversions,
    output int                o_saturated,
    output int                o_degenerate
);

    typedef struct packed {
        logic signed [OUT_W-1:0] temp_q8;
        t_status                 status;
    } t_reading;

    localparam longint SAT_LIM = longint'(1) << 62;

    // calibration copy, follows the register port
    logic [7:0]           room_whole, hot_whole;
    logic [3:0]           room_digit, hot_digit;
    logic [CODE_BITS-1:0] room_code, hot_code;
    logic signed [7:0]    room_trim, hot_trim;

    t_reading expected_q[$];
    int       fail_count;

    assign o_fail_count = fail_count;

    task automatic report(input string what, input longint got, input longint want);
        $display("MISMATCH %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic longint unsigned magnitude(input longint a);
        return a < 0 ? longint'(0) - a : a;
    endfunction

    // divide, rounding to nearest with ties away from zero
    function automatic longint div_nearest(input longint n, input longint d);
        longint unsigned q;
        if (d < 0) begin
            d = -d;
            n = -n;
        end
        q = (magnitude(n) + longint'(d) / 2) / longint'(d);
        return n < 0 ? -longint'(q) : longint'(q);
    endfunction

    // product clamped to +-2^62
    function automatic longint mul_clamped(input longint a, input longint b);
        longint unsigned ma, mb;
        logic neg;
        ma = magnitude(a);
        mb = magnitude(b);
        neg = (a < 0) != (b < 0);
        if (ma == 0 || mb == 0)
            return 0;
        if (ma > longint'(SAT_LIM) / mb)
            return neg ? -SAT_LIM : SAT_LIM;
        return neg ? -longint'(ma * mb) : longint'(ma * mb);
    endfunction

    function automatic longint point_temp(input logic [7:0] whole, input logic [3:0] digit);
        longint d;
        d = digit;
        return longint'(whole) * FRAC_ONE + div_nearest(d * FRAC_ONE, d < 10 ? 10 : 100);
    endfunction

    function automatic t_reading convert(input logic [CODE_BITS-1:0] code_in);
        t_reading r;
        longint code, t_room, t_hot, d_t, r_room, r_hot, v_room, v_hot, d_v;
        longint f1, r_mid, f2, tq, t8;
        code   = code_in;
        t_room = point_temp(room_whole, room_digit);
        t_hot  = point_temp(hot_whole, hot_digit);
        d_t    = t_hot - t_room;
        r_room = 1000 - longint'(room_trim);
        r_hot  = 1000 - longint'(hot_trim);
        v_room = longint'(room_code) * r_room;
        v_hot  = longint'(hot_code) * r_hot;
        d_v    = v_hot - v_room;
        if (d_t == 0 || d_v == 0) begin
            r.temp_q8 = '0;
            r.status  = ST_DEGEN;
            return r;
        end
        // coarse estimate, then reference at that point and a second pass
        f1    = div_nearest((code * 1000 - v_room) * FRAC_ONE, d_v);
        r_mid = r_room * FRAC_ONE + mul_clamped(r_hot - r_room, f1);
        f2    = div_nearest(mul_clamped(code, r_mid) - v_room * FRAC_ONE, d_v);
        tq    = t_room + div_nearest(mul_clamped(d_t, f2), FRAC_ONE);
        t8    = div_nearest(tq, longint'(1) << (FRAC_BITS - 8));
        r.status = ST_OK;
        if (t8 > OUT_MAX) begin
            t8 = OUT_MAX;
            r.status = ST_SAT;
        end else if (t8 < -longint'(OUT_MIN_M)) begin
            t8 = -longint'(OUT_MIN_M);
            r.status = ST_SAT;
        end
        r.temp_q8 = t8[OUT_W-1:0];
        return r;
    endfunction

    // register writes
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            room_whole <= '0;
            room_digit <= '0;
            hot_whole  <= '0;
            hot_digit  <= '0;
            room_code  <= '0;
            hot_code   <= '0;
            room_trim  <= '0;
            hot_trim   <= '0;
        end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1:2] < NUM_REGS) begin
            case (t_reg_idx'(paddr[4:2]))
                REG_ROOM_WHOLE: room_whole <= pwdata[7:0];
                REG_ROOM_DIGIT: room_digit <= pwdata[3:0];
                REG_HOT_WHOLE:  hot_whole  <= pwdata[7:0];
                REG_HOT_DIGIT:  hot_digit  <= pwdata[3:0];
                REG_ROOM_CODE:  room_code  <= pwdata[CODE_BITS-1:0];
                REG_HOT_CODE:   hot_code   <= pwdata[CODE_BITS-1:0];
                REG_ROOM_TRIM:  room_trim  <= pwdata[7:0];
                REG_HOT_TRIM:   hot_trim   <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // predict on input transfers, compare on result transfers
    always @(posedge i_clk) begin
        t_reading want;
        if (!i_rst_n) begin
            fail_count    = 0;
            o_conversions = 0;
            o_saturated   = 0;
            o_degenerate  = 0;
            expected_q.delete();
        end else begin
            if (smp.valid && smp.ready)
                expected_q.push_back(convert(smp.sensor_code));
            if (res.valid && res.ready) begin
                if (expected_q.size() == 0) begin
                    report("unexpected result temp_q8", res.temp_q8, 0);
                end else begin
                    want = expected_q.pop_front();
                    o_conversions++;
                    if (want.status == ST_SAT)
                        o_saturated++;
                    if (want.status == ST_DEGEN)
                        o_degenerate++;
                    if (res.temp_q8 !== want.temp_q8)
                        report("temp_q8", res.temp_q8, want.temp_q8);
                    if (res.status !== want.status)
                        report("status", res.status, want.status);
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

// ===== test/temp_sensor_two_point_conversion_tb.sv =====
`timescale 1ns / 100ps

module temp_sensor_two_point_conversion_tb import tcc_pkg::*;;

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;
    int                fail_count, pending, conversions, saturated, degenerate;
    int                stall_pct;
    int                sent;

    tcc_in_if  smp ();
    tcc_out_if res ();

    temp_sensor_two_point_conversion dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_smp   (smp),
        .o_res   (res)
    );

    temp_conv_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .smp           (smp),
        .res           (res),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_conversions (conversions),
        .o_saturated   (saturated),
        .o_degenerate  (degenerate)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver stalls in runs, rate set per phase
    always @(posedge i_clk) begin
        if (!i_rst_n)
            res.ready <= 1'b0;
        else if ($urandom_range(99) < 20)
            res.ready <= $urandom_range(99) >= stall_pct;
    end

    task automatic reg_write(input t_reg_idx idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx) << 2;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_cal(input int rw, input int rd, input int hw, input int hd,
                           input int rc, input int hc, input int rt, input int ht);
        reg_write(REG_ROOM_WHOLE, rw);
        reg_write(REG_ROOM_DIGIT, rd);
        reg_write(REG_HOT_WHOLE, hw);
        reg_write(REG_HOT_DIGIT, hd);
        reg_write(REG_ROOM_CODE, rc);
        reg_write(REG_HOT_CODE, hc);
        reg_write(REG_ROOM_TRIM, rt);
        reg_write(REG_HOT_TRIM, ht);
        @(posedge i_clk);
    endtask

    // one reading, held until it transfers
    task automatic send_reading(input logic [CODE_BITS-1:0] code);
        smp.valid       <= 1'b1;
        smp.sensor_code <= code;
        do @(posedge i_clk); while (!smp.ready);
        sent++;
    endtask

    // drop valid and let the clock advance first so the last transfer is already counted
    task automatic drain();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    // bursts of readings with random gaps; a pause for a full drain halfway
    task automatic run_random(input int count, input int rc, input int hc);
        int burst;
        int n;
        n = 0;
        while (n < count) begin
            burst = $urandom_range(1, 16);
            repeat (burst) begin
                if ($urandom_range(3) == 0)
                    send_reading(CODE_BITS'($urandom_range(4095)));
                else
                    send_reading(CODE_BITS'($urandom_range(rc < hc ? rc : hc,
                                                           rc < hc ? hc : rc)));
                n++;
                if (n == count / 2)
                    drain();
            end
            if ($urandom_range(3) != 0) begin
                smp.valid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
        end
        drain();
    endtask

    initial begin
        int rc, hc;
        logic [CODE_BITS-1:0] dir_codes [9];
        sent            = 0;
        stall_pct       = 30;
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        smp.valid       = 1'b0;
        smp.sensor_code = '0;
        dir_codes       = '{12'd0, 12'hFFF, 12'd1, 12'd1500, 12'd1900, 12'h800, 12'hAAA,
                            12'h555, 12'hFFE};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset calibration is degenerate
        send_reading(12'd0);
        send_reading(12'hFFF);
        drain();

        // typical points, directed codes
        set_cal(30, 0, 85, 5, 1500, 1900, 3, -4);
        foreach (dir_codes[i])
            send_reading(dir_codes[i]);
        drain();

        // extremes: widest temperatures, codes and trims, hundredth digits
        set_cal(0, 15, 255, 15, 0, 4095, 127, -128);
        send_reading(12'd0);
        send_reading(12'hFFF);
        send_reading(12'd2048);
        drain();
        set_cal(255, 10, 0, 9, 4095, 1, -128, 127);
        send_reading(12'd0);
        send_reading(12'hFFF);
        drain();
        // close codes force saturation both ways
        set_cal(25, 0, 26, 0, 2000, 2001, 0, 0);
        send_reading(12'd0);
        send_reading(12'hFFF);
        send_reading(12'd2000);
        drain();
        // equal temperatures, then equal voltages
        set_cal(50, 3, 50, 3, 1000, 2000, 0, 0);
        send_reading(12'd1234);
        drain();
        set_cal(20, 0, 90, 0, 2000, 2000, 5, 5);
        send_reading(12'd3000);
        drain();

        // random phases, receiver pressure varies, one with no stalls
        for (int ph = 0; ph < 8; ph++) begin
            stall_pct = (ph == 2) ? 0 : $urandom_range(10, 70);
            if (ph % 3 == 0) begin
                rc = $urandom_range(4095);
                hc = $urandom_range(4095);
                set_cal($urandom_range(255), $urandom_range(15), $urandom_range(255),
                        $urandom_range(15), rc, hc, $urandom_range(255),
                        $urandom_range(255));
            end else begin
                rc = $urandom_range(1000, 3000);
                hc = rc + $urandom_range(100, 900);
                set_cal($urandom_range(0, 40), $urandom_range(15), $urandom_range(60, 150),
                        $urandom_range(15), rc, hc, $urandom_range(255),
                        $urandom_range(255));
            end
            run_random(78, rc, hc);
        end

        repeat (160) @(posedge i_clk);
        $display("%0d readings sent, %0d conversions checked (%0d saturated, %0d degenerate)",
                 sent, conversions, saturated, degenerate);
        $display("covered extreme and random calibrations with random gaps and output stalls");
        if (fail_count == 0 && pending == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== temp_sensor_two_point_conversion.f =====
design/tcc_pkg.sv
design/tcc_if.sv
design/tcc_div.sv
design/temp_sensor_two_point_conversion.sv
test/temp_conv_checker.sv
test/temp_sensor_two_point_conversion_tb.sv
